>>> sv/pfe_pkg.sv
// ----------------------------------------------------------------------------
// pfe_pkg
// Shared types and constants of the postfix expression evaluator: token and
// result payloads, operation and status codes, Q16.16 limits, state types.
// ----------------------------------------------------------------------------
package pfe_pkg;

    localparam int STACK_DEPTH_DEF = 16;
    localparam int WORD_W          = 32;
    localparam int CNT_W           = $clog2(WORD_W);

    localparam logic [2:0] OP_PUSH = 3'd0;
    localparam logic [2:0] OP_ADD  = 3'd1;
    localparam logic [2:0] OP_SUB  = 3'd2;
    localparam logic [2:0] OP_MUL  = 3'd3;
    localparam logic [2:0] OP_DIV  = 3'd4;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_UNDERFLOW = 2'd1;
    localparam logic [1:0] ST_OVERFLOW  = 2'd2;
    localparam logic [1:0] ST_DIVZERO   = 2'd3;

    localparam logic [31:0] Q_MAX         = 32'h7FFF_FFFF;
    localparam logic [31:0] Q_MIN         = 32'h8000_0000;
    localparam logic [31:0] DIVZERO_VALUE = 32'hFC19_0000;
    localparam logic [63:0] ROUND_HALF    = 64'd32768;

    typedef struct packed {
        logic [2:0]         operation;
        logic signed [31:0] operand_value;
    } t_in;

    typedef struct packed {
        logic signed [31:0] top_value;
        logic [4:0]         stack_depth;
        logic [1:0]         status;
    } t_out;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_CALC,
        S_DONE
    } t_state;

    typedef enum logic [1:0] {
        A_IDLE,
        A_SETUP,
        A_RUN,
        A_FINISH
    } t_alu_state;

    typedef struct packed {
        logic        start;
        logic [2:0]  op;
        logic [31:0] left;
        logic [31:0] right;
    } t_alu_req;

    typedef struct packed {
        logic        done;
        logic        divzero;
        logic [31:0] value;
    } t_alu_rsp;

endpackage

>>> sv/postfix_expression_evaluator.sv
// ----------------------------------------------------------------------------
// postfix_expression_evaluator
// Postfix token evaluator on a bounded Q16.16 value stack. Each token yields
// one result with the top of stack, the depth and a status.
//
//   channel | direction | handshake                 | payload
//   --------+-----------+---------------------------+------------------------
//   token   | in        | i_in_valid / o_in_ready   | i_in_data  (t_in)
//   result  | out       | o_out_valid / i_out_ready | o_out_data (t_out)
//
// One token at a time. A push or an unknown token passes through the execute
// and done states; an operator also waits in the calculate state for the
// 32-step bit-serial loop of the arithmetic unit.
// The result register lets the next token transfer while a result waits.
// Reset empties the stack; stack memory contents are not cleared.
// ----------------------------------------------------------------------------
module postfix_expression_evaluator #(
    parameter int STACK_DEPTH = pfe_pkg::STACK_DEPTH_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  pfe_pkg::t_in  i_in_data,
    output logic          o_in_ready,
    output logic          o_out_valid,
    output pfe_pkg::t_out o_out_data,
    input  logic          i_out_ready
);
    import pfe_pkg::*;

    localparam int ADDR_W = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int SP_W   = $clog2(STACK_DEPTH + 1);

    t_state r_state;
    t_state n_state;

    t_in         r_tok;
    logic [SP_W-1:0] r_sp;
    logic [31:0] r_top;
    logic [1:0]  r_status;
    logic        r_under;
    t_out        r_out;
    logic        r_out_valid;
    logic [31:0] r_mem [STACK_DEPTH];
    logic [31:0] r_rd_data;

    t_alu_req alu_req;
    t_alu_rsp alu_rsp;

    logic              accept;
    logic              is_push;
    logic              is_arith;
    logic              full;
    logic              empty;
    logic              two;
    logic [SP_W-1:0]   sp_m1;
    logic [SP_W-1:0]   sp_m2;
    logic [ADDR_W-1:0] wr_addr;
    logic [ADDR_W-1:0] rd_addr;
    logic              out_load;
    logic              mem_we;

    assign accept   = i_in_valid && o_in_ready;
    assign is_push  = (r_tok.operation == OP_PUSH);
    assign is_arith = (r_tok.operation == OP_ADD) || (r_tok.operation == OP_SUB) ||
                      (r_tok.operation == OP_MUL) || (r_tok.operation == OP_DIV);
    assign full     = (r_sp == SP_W'(STACK_DEPTH));
    assign empty    = (r_sp == '0);
    assign two      = (r_sp >= SP_W'(2));
    assign sp_m1    = r_sp - SP_W'(1);
    assign sp_m2    = r_sp - SP_W'(2);
    assign wr_addr  = sp_m1[ADDR_W-1:0];
    assign rd_addr  = two ? sp_m2[ADDR_W-1:0] : '0;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: n_state = is_arith ? S_CALC : S_DONE;
            S_CALC: begin
                if (alu_rsp.done) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready    = (r_state == S_IDLE);
        alu_req.start = (r_state == S_EXEC) && is_arith;
        alu_req.op    = r_tok.operation;
        alu_req.left  = two ? r_rd_data : '0;
        alu_req.right = empty ? '0 : r_top;
        out_load      = (r_state == S_DONE) && (!r_out_valid || i_out_ready);
        mem_we        = (r_state == S_EXEC) && is_push && !full && !empty;
    end

    pfe_alu u_alu (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (alu_req),
        .o_rsp   (alu_rsp)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_sp        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if ((r_state == S_EXEC) && is_push && !full) begin
                r_sp <= r_sp + SP_W'(1);
            end else if ((r_state == S_CALC) && alu_rsp.done) begin
                r_sp <= two ? sp_m1 : SP_W'(1);
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_tok <= i_in_data;
        end
        if (r_state == S_EXEC) begin
            r_under <= !two;
            if (is_push) begin
                if (!full) begin
                    r_top <= r_tok.operand_value;
                end
                r_status <= full ? ST_OVERFLOW : ST_OK;
            end else if (!is_arith) begin
                r_status <= ST_OK;
            end
        end
        if ((r_state == S_CALC) && alu_rsp.done) begin
            r_top <= alu_rsp.value;
            if (r_under) begin
                r_status <= ST_UNDERFLOW;
            end else if (alu_rsp.divzero && (r_tok.operation == OP_DIV)) begin
                r_status <= ST_DIVZERO;
            end else begin
                r_status <= ST_OK;
            end
        end
        if (out_load) begin
            r_out.top_value   <= empty ? '0 : r_top;
            r_out.stack_depth <= 5'(r_sp);
            r_out.status      <= r_status;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[wr_addr] <= r_top;
        end
        r_rd_data <= r_mem[rd_addr];
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

>>> sv/pfe_alu.sv
// ----------------------------------------------------------------------------
// pfe_alu
// Bit-serial Q16.16 arithmetic unit: serial add and subtract, shift-add
// signed multiply with rounding, restoring divide, all with saturation.
// One operand bit per cycle in the run state, between a setup and a finish state.
// ----------------------------------------------------------------------------
module pfe_alu (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  pfe_pkg::t_alu_req i_req,
    output pfe_pkg::t_alu_rsp o_rsp
);
    import pfe_pkg::*;

    t_alu_state r_state;
    t_alu_state n_state;

    logic [2:0]       r_op;
    logic [31:0]      r_x;
    logic [31:0]      r_y;
    logic [31:0]      r_hi;
    logic [31:0]      r_lo;
    logic             r_c;
    logic             r_ov;
    logic             r_sgn;
    logic             r_neg;
    logic             r_big;
    logic             r_dz;
    logic [CNT_W-1:0] r_cnt;
    logic [31:0]      r_res;
    logic             r_done;

    logic        do_start;
    logic        do_setup;
    logic        do_run;
    logic        do_finish;
    logic        last;
    logic        sub;
    logic        ai;
    logic        bi;
    logic        s_bit;
    logic        c_next;
    logic [32:0] addend;
    logic [32:0] msum;
    logic [32:0] dt;
    logic [32:0] ddiff;
    logic        dge;
    logic [31:0] absx;
    logic [31:0] absy;
    logic [63:0] psum;
    logic        mul_sat;
    logic [31:0] mul_val;
    logic [31:0] div_val;
    logic [31:0] addsub_val;
    logic [31:0] res_val;

    always_comb begin
        n_state = r_state;
        case (r_state)
            A_IDLE: begin
                if (i_req.start) begin
                    n_state = A_SETUP;
                end
            end
            A_SETUP:  n_state = A_RUN;
            A_RUN: begin
                if (last) begin
                    n_state = A_FINISH;
                end
            end
            A_FINISH: n_state = A_IDLE;
            default:  n_state = A_IDLE;
        endcase
    end

    always_comb begin
        do_start  = 1'b0;
        do_setup  = 1'b0;
        do_run    = 1'b0;
        do_finish = 1'b0;
        case (r_state)
            A_IDLE:   do_start  = i_req.start;
            A_SETUP:  do_setup  = 1'b1;
            A_RUN:    do_run    = 1'b1;
            A_FINISH: do_finish = 1'b1;
            default:  do_start  = 1'b0;
        endcase
    end

    assign last = (r_cnt == CNT_W'(WORD_W - 1));
    assign sub  = (r_op == OP_SUB);

    assign ai     = r_x[0];
    assign bi     = r_y[0] ^ sub;
    assign s_bit  = ai ^ bi ^ r_c;
    assign c_next = (ai & bi) | (ai & r_c) | (bi & r_c);

    always_comb begin
        if (!r_lo[0]) begin
            addend = '0;
        end else if (last) begin
            addend = -{r_x[31], r_x};
        end else begin
            addend = {r_x[31], r_x};
        end
    end
    assign msum = {r_hi[31], r_hi} + addend;

    assign dt    = {r_hi, r_lo[31]};
    assign ddiff = dt - {1'b0, r_y};
    assign dge   = (dt >= {1'b0, r_y});

    assign absx = r_x[31] ? -r_x : r_x;
    assign absy = r_y[31] ? -r_y : r_y;

    assign psum    = {r_hi, r_lo} + ROUND_HALF;
    assign mul_sat = ~(&psum[63:47]) & (|psum[63:47]);
    assign mul_val = mul_sat ? (psum[63] ? Q_MIN : Q_MAX) : psum[47:16];

    always_comb begin
        if (r_dz) begin
            div_val = DIVZERO_VALUE;
        end else if (r_big) begin
            div_val = r_neg ? Q_MIN : Q_MAX;
        end else if (!r_neg) begin
            div_val = r_lo[31] ? Q_MAX : r_lo;
        end else begin
            div_val = (r_lo[31] && (|r_lo[30:0])) ? Q_MIN : -r_lo;
        end
    end

    assign addsub_val = r_ov ? (r_sgn ? Q_MIN : Q_MAX) : r_lo;

    always_comb begin
        case (r_op)
            OP_MUL:  res_val = mul_val;
            OP_DIV:  res_val = div_val;
            default: res_val = addsub_val;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= A_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= do_finish;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_start) begin
            r_op <= i_req.op;
            r_x  <= i_req.left;
            r_y  <= i_req.right;
        end
        if (do_setup) begin
            r_cnt <= '0;
            case (r_op)
                OP_MUL: begin
                    r_lo <= r_y;
                    r_hi <= '0;
                    r_dz <= 1'b0;
                end
                OP_DIV: begin
                    r_neg <= r_x[31] ^ r_y[31];
                    r_y   <= absy;
                    r_hi  <= {16'b0, absx[31:16]};
                    r_lo  <= {absx[15:0], 16'b0};
                    r_big <= ({16'b0, absx[31:16]} >= absy);
                    r_dz  <= (r_y == '0);
                end
                default: begin
                    r_c  <= sub;
                    r_dz <= 1'b0;
                end
            endcase
        end
        if (do_run) begin
            r_cnt <= r_cnt + CNT_W'(1);
            case (r_op)
                OP_MUL: begin
                    r_hi <= msum[32:1];
                    r_lo <= {msum[0], r_lo[31:1]};
                end
                OP_DIV: begin
                    r_hi <= dge ? ddiff[31:0] : dt[31:0];
                    r_lo <= {r_lo[30:0], dge};
                end
                default: begin
                    r_x  <= {1'b0, r_x[31:1]};
                    r_y  <= {1'b0, r_y[31:1]};
                    r_lo <= {s_bit, r_lo[31:1]};
                    r_c  <= c_next;
                    if (last) begin
                        r_ov  <= (ai == bi) && (s_bit != ai);
                        r_sgn <= ai;
                    end
                end
            endcase
        end
        if (do_finish) begin
            r_res <= res_val;
        end
    end

    assign o_rsp.done    = r_done;
    assign o_rsp.divzero = r_dz;
    assign o_rsp.value   = r_res;

endmodule

>>> sv/pfe_checker.sv
// ----------------------------------------------------------------------------
// pfe_checker
// Port-level checks of the postfix expression evaluator, bound to the top.
// ----------------------------------------------------------------------------
module pfe_checker #(
    parameter int STACK_DEPTH = pfe_pkg::STACK_DEPTH_DEF
) (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          i_in_valid,
    input logic          o_in_ready,
    input logic          o_out_valid,
    input pfe_pkg::t_out o_out_data,
    input logic          i_out_ready
);
    import pfe_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("result changed while stalled");

    a_one_token: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("token taken while previous token in flight");

    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_data.stack_depth == 5'd0) |-> (o_out_data.top_value == '0))
        else $error("empty stack shows nonzero top");

    a_overflow_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_data.status == ST_OVERFLOW)
        |-> (o_out_data.stack_depth == 5'(STACK_DEPTH)))
        else $error("overflow reported on a stack that is not full");

    a_divzero_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_data.status == ST_DIVZERO)
        |-> (o_out_data.top_value == DIVZERO_VALUE))
        else $error("division by zero without the fill value on top");

endmodule

bind postfix_expression_evaluator pfe_checker #(
    .STACK_DEPTH (STACK_DEPTH)
) u_pfe_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .o_out_data  (o_out_data),
    .i_out_ready (i_out_ready)
);
